>>> rtl/swsc_pkg.sv
// Shared widths, register codes and controller/datapath bundles for the
// sliding-window slope convergence unit. No dependencies.
package swsc_pkg;

    // Field widths of the stream payloads and registers
    localparam int STEP_W     = 24;
    localparam int VAL_W      = 48;
    localparam int HALF_W     = 24;
    localparam int INTV_W     = 16;
    localparam int TOL_W      = 47;
    localparam int IN_DATA_W  = 72;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_USER_W = 3;
    localparam int CFG_IDX_W  = 1;

    // Quotient bits produced by the serial divider
    localparam int QBITS  = 48;
    localparam int QCNT_W = 6;

    // Window size defaults
    localparam int MAX_POINTS_DEF = 10;
    localparam int MIN_POINTS_DEF = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_INTERVAL  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_TOLERANCE = 1'b1;

    // Register reset values
    localparam logic [INTV_W-1:0] INTERVAL_RST  = 16'd1;
    localparam logic [TOL_W-1:0]  TOLERANCE_RST = 47'd1099;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_in;    // capture the input beat
        logic clear_win;  // empty the window, drop converged
        logic write_win;  // append the held sample
        logic acc_clr;    // zero the sums
        logic rd_rewind;  // read the oldest entry
        logic rd_go;      // read the next entry
        logic sum_rd;     // this read feeds the step sum
        logic calc_c;     // centered step of the read entry
        logic mul;        // products of the read entry
        logic acc1;       // add denominator and low numerator product
        logic acc2;       // add high numerator product
        logic mag;        // split numerator into sign and magnitude
        logic div_init;   // load the divider
        logic div_step;   // one quotient bit
        logic finish;     // saturate, store slope, update converged
        logic out_load;   // fill the output register
    } swsc_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_clear;   // held item is a clear
        logic take_ok;    // held sample is measured and far enough along
        logic den_pos;    // fit is not degenerate
        logic div_big;    // quotient would need more than QBITS bits
    } swsc_stat_t;

endpackage

>>> rtl/swsc_datapath.sv
// Datapath of the slope convergence unit: window memory, sums, multipliers,
// serial divider, configuration and output registers. Uses swsc_pkg.
module swsc_datapath #(
    parameter int MAX_POINTS = swsc_pkg::MAX_POINTS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  swsc_pkg::swsc_cmd_t                     cmd,
    output swsc_pkg::swsc_stat_t                    stat,
    output logic [$clog2(MAX_POINTS+1)-1:0]         fill,
    input  logic [swsc_pkg::IN_DATA_W-1:0]          s_tdata,
    input  logic [swsc_pkg::IN_USER_W-1:0]          s_tuser,
    input  logic                                    cfg_valid,
    input  logic [swsc_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [swsc_pkg::TOL_W-1:0]              cfg_data,
    output logic [swsc_pkg::OUT_DATA_W-1:0]         m_tdata,
    output logic [swsc_pkg::OUT_USER_W-1:0]         m_tuser
);
    import swsc_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int SX_W  = STEP_W + CNT_W;
    localparam int C_W   = SX_W + 1;
    localparam int PD_W  = C_W + STEP_W + 1;
    localparam int PL_W  = C_W + HALF_W + 1;
    localparam int PH_W  = C_W + HALF_W;
    localparam int DEN_W = PD_W + CNT_W;
    localparam int NUM_W = C_W + VAL_W + CNT_W;
    localparam int BIG_W = DEN_W + QBITS;
    localparam int ENT_W = STEP_W + VAL_W;
    localparam int DIF_W = STEP_W + 2;

    localparam logic [QBITS-1:0] POS_LIM = {1'b0, {(QBITS-1){1'b1}}};
    localparam logic [QBITS-1:0] NEG_LIM = {1'b1, {(QBITS-1){1'b0}}};

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
        return (p == IDX_W'(MAX_POINTS - 1)) ? '0 : p + 1'b1;
    endfunction

    // Held input item
    logic                     func_reg;
    logic                     meas_reg;
    logic [STEP_W-1:0]        step_reg;
    logic signed [VAL_W-1:0]  val_reg;

    // Window bookkeeping and configuration
    logic [CNT_W-1:0]         fill_reg;
    logic [IDX_W-1:0]         head_reg;
    logic [IDX_W-1:0]         rd_ptr_reg;
    logic                     sx_pend_reg;
    logic [STEP_W-1:0]        last_step_reg;
    logic [INTV_W-1:0]        interval_reg;
    logic [TOL_W-1:0]         tol_reg;
    logic                     conv_reg;
    logic                     taken_reg;
    logic                     fresh_reg;
    logic signed [VAL_W-1:0]  last_slope_reg;

    // Window memory
    logic [ENT_W-1:0]         win_mem [MAX_POINTS];
    logic [ENT_W-1:0]         rd_data_reg;

    // Fit arithmetic
    logic [SX_W-1:0]          sx_reg;
    logic signed [C_W-1:0]    c_reg;
    logic signed [PD_W-1:0]   p_den_reg;
    logic signed [PL_W-1:0]   p_lo_reg;
    logic signed [PH_W-1:0]   p_hi_reg;
    logic signed [DEN_W-1:0]  den_reg;
    logic signed [NUM_W-1:0]  num_reg;
    logic                     neg_reg;
    logic [NUM_W-1:0]         mag_reg;
    logic [DEN_W-1:0]         rem_reg;
    logic [QBITS-1:0]         sh_reg;
    logic [QBITS-1:0]         q_reg;

    // Output register
    logic [OUT_DATA_W-1:0]    out_data_reg;
    logic [OUT_USER_W-1:0]    out_user_reg;

    logic                     full;
    logic [IDX_W:0]           tail_sum;
    logic [IDX_W-1:0]         wr_addr;
    logic [IDX_W-1:0]         rd_addr;
    logic [STEP_W-1:0]        rd_step;
    logic signed [VAL_W-1:0]  rd_val;
    logic [STEP_W-1:0]        last_step;
    logic signed [DIF_W-1:0]  step_diff;
    logic [DEN_W-1:0]         den_u;
    logic [DEN_W-1:0]         trial;
    logic                     trial_ge;
    logic [QBITS-1:0]         q_lim;
    logic [QBITS-1:0]         q_sat;
    logic [VAL_W-1:0]         slope_fin;

    // Address the circular window
    assign full     = (fill_reg == CNT_W'(MAX_POINTS));
    assign tail_sum = {1'b0, head_reg} + (IDX_W+1)'(fill_reg);
    always_comb
    begin
        if (full)
        begin
            wr_addr = head_reg;
        end
        else if (tail_sum >= (IDX_W+1)'(MAX_POINTS))
        begin
            wr_addr = IDX_W'(tail_sum - (IDX_W+1)'(MAX_POINTS));
        end
        else
        begin
            wr_addr = tail_sum[IDX_W-1:0];
        end
    end
    assign rd_addr = cmd.rd_rewind ? head_reg : rd_ptr_reg;
    assign rd_step = rd_data_reg[ENT_W-1:VAL_W];
    assign rd_val  = $signed(rd_data_reg[VAL_W-1:0]);

    // Check the step distance against the newest stored step
    assign last_step = (fill_reg != '0) ? last_step_reg : '0;
    assign step_diff = $signed({2'b00, step_reg}) - $signed({2'b00, last_step});

    // Divider step and final saturation
    assign den_u    = $unsigned(den_reg);
    assign trial    = {rem_reg[DEN_W-2:0], sh_reg[QBITS-1]};
    assign trial_ge = (trial >= den_u);
    assign q_lim    = neg_reg ? NEG_LIM : POS_LIM;
    assign q_sat    = (q_reg > q_lim) ? q_lim : q_reg;
    assign slope_fin = neg_reg ? VAL_W'(-q_sat) : VAL_W'(q_sat);

    // Report status
    always_comb
    begin
        stat.is_clear = func_reg;
        stat.take_ok  = meas_reg &&
                        (step_diff >= $signed({(DIF_W-INTV_W)'(0), interval_reg}));
        stat.den_pos  = (den_reg > 0);
        stat.div_big  = (BIG_W'(mag_reg) >= {den_u, {QBITS{1'b0}}});
    end

    // Window memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.write_win)
        begin
            win_mem[wr_addr] <= {step_reg, val_reg};
        end
        if (cmd.rd_rewind || cmd.rd_go)
        begin
            rd_data_reg <= win_mem[rd_addr];
        end
    end

    // Control state, configuration and result flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            head_reg       <= '0;
            rd_ptr_reg     <= '0;
            sx_pend_reg    <= 1'b0;
            interval_reg   <= INTERVAL_RST;
            tol_reg        <= TOLERANCE_RST;
            conv_reg       <= 1'b0;
            taken_reg      <= 1'b0;
            fresh_reg      <= 1'b0;
            last_slope_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_CHECK_INTERVAL:  interval_reg <= cfg_data[INTV_W-1:0];
                    CFG_SLOPE_TOLERANCE: tol_reg      <= cfg_data;
                    default:             ;
                endcase
            end
            if (cmd.load_in)
            begin
                taken_reg <= 1'b0;
                fresh_reg <= 1'b0;
            end
            if (cmd.clear_win)
            begin
                fill_reg <= '0;
                conv_reg <= 1'b0;
            end
            // Append; when full the oldest entry is overwritten
            if (cmd.write_win)
            begin
                taken_reg <= 1'b1;
                if (full)
                begin
                    head_reg <= wrap_inc(head_reg);
                end
                else
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (cmd.rd_rewind)
            begin
                rd_ptr_reg <= wrap_inc(head_reg);
            end
            else if (cmd.rd_go)
            begin
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            end
            sx_pend_reg <= cmd.sum_rd;
            if (cmd.finish)
            begin
                last_slope_reg <= $signed(slope_fin);
                fresh_reg      <= 1'b1;
                if (q_sat < {1'b0, tol_reg})
                begin
                    conv_reg <= 1'b1;
                end
            end
        end
    end

    // Payload: held item, sums, products, divider, output beat
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            step_reg <= s_tdata[STEP_W-1:0];
            val_reg  <= $signed(s_tdata[STEP_W+VAL_W-1:STEP_W]);
            func_reg <= s_tuser[0];
            meas_reg <= s_tuser[1];
        end
        if (cmd.write_win)
        begin
            last_step_reg <= step_reg;
        end
        if (cmd.acc_clr)
        begin
            sx_reg  <= '0;
            den_reg <= '0;
            num_reg <= '0;
        end
        else
        begin
            if (sx_pend_reg)
            begin
                sx_reg <= sx_reg + SX_W'(rd_step);
            end
            if (cmd.acc1)
            begin
                den_reg <= den_reg + DEN_W'(p_den_reg);
                num_reg <= num_reg + NUM_W'(p_lo_reg);
            end
            else if (cmd.acc2)
            begin
                num_reg <= num_reg + (NUM_W'(p_hi_reg) <<< HALF_W);
            end
        end
        // Centered step: n * x_i - sum(x)
        if (cmd.calc_c)
        begin
            c_reg <= $signed(C_W'(SX_W'(fill_reg) * SX_W'(rd_step))) -
                     $signed(C_W'(sx_reg));
        end
        // Products with the value split into two halves
        if (cmd.mul)
        begin
            p_den_reg <= c_reg * $signed({1'b0, rd_step});
            p_lo_reg  <= c_reg * $signed({1'b0, rd_val[HALF_W-1:0]});
            p_hi_reg  <= c_reg * $signed(rd_val[VAL_W-1:HALF_W]);
        end
        if (cmd.mag)
        begin
            neg_reg <= num_reg[NUM_W-1];
            mag_reg <= num_reg[NUM_W-1] ? $unsigned(-num_reg) : $unsigned(num_reg);
        end
        // Restoring division, one quotient bit per step
        if (cmd.div_init)
        begin
            rem_reg <= DEN_W'(mag_reg >> QBITS);
            sh_reg  <= mag_reg[QBITS-1:0];
            q_reg   <= stat.div_big ? '1 : '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? trial - den_u : trial;
            sh_reg  <= sh_reg << 1;
            q_reg   <= {q_reg[QBITS-2:0], trial_ge};
        end
        if (cmd.out_load)
        begin
            out_data_reg <= $unsigned(last_slope_reg);
            out_user_reg <= {conv_reg, taken_reg, fresh_reg};
        end
    end

    assign fill    = fill_reg;
    assign m_tdata = out_data_reg;
    assign m_tuser = out_user_reg;

endmodule

>>> rtl/swsc_ctrl.sv
// Controller of the slope convergence unit: sequences one item through check,
// append, summing, per-point products, division and output. Uses swsc_pkg.
module swsc_ctrl #(
    parameter int MAX_POINTS = swsc_pkg::MAX_POINTS_DEF,
    parameter int MIN_POINTS = swsc_pkg::MIN_POINTS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output swsc_pkg::swsc_cmd_t                cmd,
    input  swsc_pkg::swsc_stat_t               stat,
    input  logic [$clog2(MAX_POINTS+1)-1:0]    fill
);
    import swsc_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_WRITE = 4'd2;
    localparam logic [3:0] S_SUM0  = 4'd3;
    localparam logic [3:0] S_SUM   = 4'd4;
    localparam logic [3:0] S_EC    = 4'd5;
    localparam logic [3:0] S_EMUL  = 4'd6;
    localparam logic [3:0] S_EACC1 = 4'd7;
    localparam logic [3:0] S_EACC2 = 4'd8;
    localparam logic [3:0] S_MAG   = 4'd9;
    localparam logic [3:0] S_DCHK  = 4'd10;
    localparam logic [3:0] S_DIV   = 4'd11;
    localparam logic [3:0] S_FIN   = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    logic [3:0]        state_reg;
    logic [3:0]        state_next;
    logic [CNT_W-1:0]  elem_reg;
    logic [CNT_W-1:0]  elem_next;
    logic [CNT_W-1:0]  elem_inc;
    logic [QCNT_W-1:0] qcnt_reg;
    logic [QCNT_W-1:0] qcnt_next;
    logic              m_tvalid_reg;
    logic [CNT_W:0]    fill_after;

    assign elem_inc   = elem_reg + 1'b1;
    assign fill_after = (fill == CNT_W'(MAX_POINTS)) ? {1'b0, fill}
                                                     : {1'b0, fill} + 1'b1;

    // Sequence one item
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        elem_next  = elem_reg;
        qcnt_next  = qcnt_reg;
        s_tready   = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.is_clear)
                begin
                    cmd.clear_win = 1'b1;
                    state_next    = S_OUT;
                end
                else if (stat.take_ok)
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_WRITE:
            begin
                cmd.write_win = 1'b1;
                state_next = (int'(fill_after) >= MIN_POINTS) ? S_SUM0 : S_OUT;
            end
            // Sum the steps; the last cycle drains and fetches the first entry
            S_SUM0:
            begin
                cmd.acc_clr   = 1'b1;
                cmd.rd_rewind = 1'b1;
                cmd.sum_rd    = 1'b1;
                elem_next     = CNT_W'(1);
                state_next    = S_SUM;
            end
            S_SUM:
            begin
                if (elem_reg < fill)
                begin
                    cmd.rd_go  = 1'b1;
                    cmd.sum_rd = 1'b1;
                    elem_next  = elem_inc;
                end
                else
                begin
                    cmd.rd_rewind = 1'b1;
                    elem_next     = '0;
                    state_next    = S_EC;
                end
            end
            S_EC:
            begin
                cmd.calc_c = 1'b1;
                state_next = S_EMUL;
            end
            S_EMUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_EACC1;
            end
            S_EACC1:
            begin
                cmd.acc1   = 1'b1;
                state_next = S_EACC2;
            end
            S_EACC2:
            begin
                cmd.acc2 = 1'b1;
                if (elem_inc < fill)
                begin
                    cmd.rd_go  = 1'b1;
                    elem_next  = elem_inc;
                    state_next = S_EC;
                end
                else
                begin
                    state_next = S_MAG;
                end
            end
            S_MAG:
            begin
                cmd.mag    = 1'b1;
                state_next = S_DCHK;
            end
            // Drop a degenerate fit; skip the divider when it would overflow
            S_DCHK:
            begin
                if (!stat.den_pos)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    qcnt_next    = '0;
                    state_next   = stat.div_big ? S_FIN : S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                qcnt_next    = qcnt_reg + 1'b1;
                if (qcnt_reg == QCNT_W'(QBITS - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            // Hand the result to the output register once it is free
            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Advance state, counters and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            elem_reg     <= '0;
            qcnt_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            elem_reg  <= elem_next;
            qcnt_reg  <= qcnt_next;
            if (cmd.out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

>>> rtl/sliding_window_slope_convergence_unit.sv
// Sliding-window slope convergence unit. Takes one item at a time and returns
// one result beat per item. A clear, an ignored sample and a sample taken
// below the minimum point count go to the result beat without a fit; a sample
// that triggers a fit first sums the steps in the window, then makes the
// multiply-accumulate pass through the window memory point by point, then runs
// the bit-serial divider, which is skipped when the slope is known to saturate.
// The finished beat waits in an output register, so the next item is accepted
// while it is still pending. Configuration writes are taken every cycle and
// must be issued while no item is in progress.
// Top level: joins swsc_ctrl and swsc_datapath; uses swsc_pkg.
module sliding_window_slope_convergence_unit #(
    parameter int MAX_POINTS = swsc_pkg::MAX_POINTS_DEF,
    parameter int MIN_POINTS = swsc_pkg::MIN_POINTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [23:0] step_number, [71:24] sample_value
    input  logic [swsc_pkg::IN_DATA_W-1:0]    s_tdata,
    // [0] func, [1] is_measured
    input  logic [swsc_pkg::IN_USER_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [47:0] slope_out
    output logic [swsc_pkg::OUT_DATA_W-1:0]   m_tdata,
    // [0] slope_fresh, [1] sample_taken, [2] converged
    output logic [swsc_pkg::OUT_USER_W-1:0]   m_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [swsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [swsc_pkg::TOL_W-1:0]        cfg_data
);
    import swsc_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    swsc_cmd_t        cmd;
    swsc_stat_t       stat;
    logic [CNT_W-1:0] fill;

    assign cfg_ready = 1'b1;

    swsc_ctrl #(
        .MAX_POINTS (MAX_POINTS),
        .MIN_POINTS (MIN_POINTS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat),
        .fill     (fill)
    );

    swsc_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .fill      (fill),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

>>> rtl/swsc_checker.sv
// Port-level checks for the slope convergence unit, bound to its top level.
// Uses swsc_pkg for port widths.
module swsc_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [swsc_pkg::OUT_DATA_W-1:0]   m_tdata,
    input logic [swsc_pkg::OUT_USER_W-1:0]   m_tuser
);
    import swsc_pkg::*;

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // A fresh slope only comes from a sample that entered the window
    a_fresh_taken: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!m_tuser[0] || m_tuser[1]))
        else $error("fresh slope without a taken sample");

    // One item at a time: input closes right after a beat is taken
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted while one is in work");

    // A result appears only while an item is in work
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result beat without an item in work");

endmodule

bind sliding_window_slope_convergence_unit swsc_checker u_swsc_checker (.*);

>>> verif/tb_sliding_window_slope_convergence_unit.sv
// Self-checking testbench for sliding_window_slope_convergence_unit: streams
// iteration-stamped samples and clears, predicts each result beat in place.
// Depends on swsc_pkg and the unit's RTL only.

typedef struct packed {
    logic        func;
    logic [23:0] step;
    logic [47:0] value;
    logic        measured;
} sample_beat_t;

typedef struct packed {
    logic signed [47:0] slope;
    logic               fresh;
    logic               taken;
    logic               conv;
} slope_report_t;

// Window predictor plus the ring of result beats still owed by the unit
class slope_scoreboard;
    localparam int OWED_DEPTH = 16;

    longint        step_win[swsc_pkg::MAX_POINTS_DEF];
    longint        val_win[swsc_pkg::MAX_POINTS_DEF];
    int            fill;
    bit            conv_flag;
    longint        last_slope;
    longint        interval;
    longint        tolerance;
    slope_report_t owed[OWED_DEPTH];
    int            owed_rd;
    int            owed_wr;
    int            owed_cnt;
    int            faults;
    int            results_seen;

    function new();
        fill = 0;
        conv_flag = 1'b0;
        last_slope = 0;
        interval = swsc_pkg::INTERVAL_RST;
        tolerance = swsc_pkg::TOLERANCE_RST;
        owed_rd = 0;
        owed_wr = 0;
        owed_cnt = 0;
        faults = 0;
        results_seen = 0;
    endfunction

    function void write_reg(logic [swsc_pkg::CFG_IDX_W-1:0] idx,
                            logic [swsc_pkg::TOL_W-1:0] data);
        if (idx == swsc_pkg::CFG_CHECK_INTERVAL)
            interval = data[swsc_pkg::INTV_W-1:0];
        else
            tolerance = data;
    endfunction

    function int pending();
        return owed_cnt;
    endfunction

    // Append an expected beat to the ring
    function void stash_expect(slope_report_t r);
        owed[owed_wr] = r;
        owed_wr = (owed_wr + 1) % OWED_DEPTH;
        owed_cnt++;
    endfunction

    // Take the oldest expected beat off the ring
    function slope_report_t take_expect();
        slope_report_t r;
        r = owed[owed_rd];
        owed_rd = (owed_rd + 1) % OWED_DEPTH;
        owed_cnt--;
        return r;
    endfunction

    // Count a failure; print only the first few
    function void note_fault(string what, slope_report_t want, slope_report_t got);
        faults++;
        if (faults <= 10)
            $display("result %0d %s: slope exp %h got %h, fresh %b/%b, taken %b/%b, conv %b/%b",
                     results_seen, what, want.slope, got.slope, want.fresh, got.fresh,
                     want.taken, got.taken, want.conv, got.conv);
    endfunction

    // Exact least-squares slope, truncated toward zero and saturated;
    // returns 0 when every step in the window is the same
    function bit fit_window_slope(output longint slope);
        longint              sum_steps;
        longint              centered;
        longint              denom;
        logic signed [127:0] numer;
        logic signed [127:0] term_c;
        logic signed [127:0] term_y;
        logic signed [127:0] quot;
        logic signed [127:0] top;
        logic signed [127:0] bottom;
        int                  i;
        sum_steps = 0;
        denom = 0;
        numer = '0;
        slope = 0;
        top = 128'sh7FFF_FFFF_FFFF;
        bottom = -top - 1;
        for (i = 0; i < fill; i++)
            sum_steps += step_win[i];
        for (i = 0; i < fill; i++)
        begin
            centered = longint'(fill) * step_win[i] - sum_steps;
            denom += centered * step_win[i];
            term_c = centered;
            term_y = val_win[i];
            numer += term_c * term_y;
        end
        if (denom <= 0)
            return 1'b0;
        term_c = denom;
        quot = numer / term_c;
        if (quot > top)
            quot = top;
        else if (quot < bottom)
            quot = bottom;
        slope = quot[63:0];
        return 1'b1;
    endfunction

    // Advance the window by one accepted input beat and queue its result
    function slope_report_t note_input(sample_beat_t b);
        slope_report_t r;
        longint        newest;
        longint        st;
        longint        fitted;
        longint        mag;
        int            i;
        r.fresh = 1'b0;
        r.taken = 1'b0;
        st = b.step;
        if (b.func)
        begin
            fill = 0;
            conv_flag = 1'b0;
        end
        else if (b.measured)
        begin
            newest = (fill > 0) ? step_win[fill-1] : 0;
            if (st - newest >= interval)
            begin
                r.taken = 1'b1;
                // Drop the oldest point when full
                if (fill >= swsc_pkg::MAX_POINTS_DEF)
                begin
                    for (i = 1; i < swsc_pkg::MAX_POINTS_DEF; i++)
                    begin
                        step_win[i-1] = step_win[i];
                        val_win[i-1] = val_win[i];
                    end
                    fill = swsc_pkg::MAX_POINTS_DEF - 1;
                end
                step_win[fill] = st;
                val_win[fill] = $signed(b.value);
                fill++;
                if (fill >= swsc_pkg::MIN_POINTS_DEF && fit_window_slope(fitted))
                begin
                    r.fresh = 1'b1;
                    last_slope = fitted;
                    mag = (fitted < 0) ? -fitted : fitted;
                    if (mag < tolerance)
                        conv_flag = 1'b1;
                end
            end
        end
        r.slope = last_slope[47:0];
        r.conv = conv_flag;
        stash_expect(r);
        return r;
    endfunction

    // Compare one result beat against the oldest expectation
    function void check_result(slope_report_t got);
        slope_report_t want;
        results_seen++;
        if (owed_cnt == 0)
        begin
            want = '0;
            note_fault("unexpected", want, got);
            return;
        end
        want = take_expect();
        if (got.slope !== want.slope || got.fresh !== want.fresh ||
            got.taken !== want.taken || got.conv !== want.conv)
            note_fault("mismatch", want, got);
    endfunction

    function void close_out();
        slope_report_t none;
        none = '0;
        while (owed_cnt != 0)
            note_fault("missing", take_expect(), none);
    endfunction
endclass

module tb_sliding_window_slope_convergence_unit;
    import swsc_pkg::*;

    localparam logic [47:0]      Q_MIN          = 48'h8000_0000_0000;
    localparam logic [47:0]      Q_MAX          = 48'h7FFF_FFFF_FFFF;
    localparam logic [TOL_W-1:0] TOL_MAX        = 47'h7FFF_FFFF_FFFF;
    localparam int               SETTLE_CYCLES  = 128;
    localparam int               WATCHDOG_LIMIT = 3000;
    localparam int               HOLD_AT        = 600;
    localparam int               LONG_HOLD      = 500;
    localparam int               PHASE_BEATS    = 125;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [IN_USER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [TOL_W-1:0]      cfg_data = '0;

    slope_scoreboard tracker;
    int              send_idle_pct = 33;
    int              recv_idle_pct = 62;
    int              beats_counted = 0;
    longint          gen_interval = INTERVAL_RST;
    int              hold_left = 0;
    bit              hold_done = 1'b0;
    int              quiet_cycles = 0;

    sliding_window_slope_convergence_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [47:0] random_q740();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[47:0];
    endfunction

    function automatic sample_beat_t make_beat(logic func, logic [23:0] step,
                                               logic [47:0] value, logic measured);
        sample_beat_t b;
        b.func = func;
        b.step = step;
        b.value = value;
        b.measured = measured;
        return b;
    endfunction

    // Offer one beat after a random gap and hold it until accepted
    task automatic send_item(input sample_beat_t b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {b.value, b.step};
        s_tuser <= {b.measured, b.func};
        do @(posedge clk); while (!s_tready);
        void'(tracker.note_input(b));
        beats_counted++;
    endtask

    // Write both registers back to back, then release the channel
    task automatic program_regs(input logic [INTV_W-1:0] interval,
                                input logic [TOL_W-1:0] tol);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_CHECK_INTERVAL;
        cfg_data <= {{(TOL_W-INTV_W){1'b0}}, interval};
        do @(posedge clk); while (!cfg_ready);
        tracker.write_reg(CFG_CHECK_INTERVAL, {{(TOL_W-INTV_W){1'b0}}, interval});
        cfg_index <= CFG_SLOPE_TOLERANCE;
        cfg_data <= tol;
        do @(posedge clk); while (!cfg_ready);
        tracker.write_reg(CFG_SLOPE_TOLERANCE, tol);
        cfg_valid <= 1'b0;
        gen_interval = interval;
    endtask

    // Drain all owed results, then let the unit go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One trajectory: usually a clear, then a noisy line of samples
    task automatic send_run();
        longint base;
        longint k;
        longint v;
        longint st;
        longint st0;
        longint cand;
        int     noise_amp;
        int     spread;
        int     len;
        int     pick;
        int     n;
        if ($urandom_range(0, 4) != 0)
            send_item(make_beat(1'b1, 24'($urandom), random_q740(),
                                1'($urandom_range(0, 1))));
        base = $signed(random_q740());
        pick = $urandom_range(0, 9);
        if (pick < 6)
            k = longint'($urandom_range(0, 2000)) - 1000;
        else if (pick < 9)
            k = $signed($urandom);
        else
            k = $signed(random_q740());
        case ($urandom_range(0, 2))
            0: noise_amp = 0;
            1: noise_amp = 16;
            default: noise_amp = 1 << 20;
        endcase
        spread = ($urandom_range(0, 3) == 0) ? 1000 : 3;
        st0 = $urandom_range(0, 24'hDFFFFF);
        st = st0;
        len = $urandom_range(3, 14);
        for (n = 0; n < len; n++)
        begin
            // Mostly advance by at least the interval; now and then step back
            if (n == 0)
                cand = st;
            else if ($urandom_range(0, 19) == 0)
                cand = st - $urandom_range(0, 3);
            else
            begin
                st = st + gen_interval + $urandom_range(0, spread);
                cand = st;
            end
            v = base + k * (cand - st0);
            if (noise_amp > 0)
                v += longint'($urandom_range(0, 2 * noise_amp)) - noise_amp;
            send_item(make_beat(1'b0, cand[23:0], v[47:0], $urandom_range(0, 11) != 0));
        end
    endtask

    task automatic run_random(input int quota);
        int start_cnt;
        start_cnt = beats_counted;
        while (beats_counted - start_cnt < quota)
        begin
            if ($urandom_range(0, 99) < 8)
                send_item(make_beat($urandom_range(0, 3) == 0, 24'($urandom),
                                    random_q740(), 1'($urandom_range(0, 1))));
            else
                send_run();
        end
    endtask

    // Result sink: check each beat, pick the next ready, long hold once
    always @(posedge clk)
    begin : result_sink
        slope_report_t got;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata, m_tuser[0], m_tuser[1], m_tuser[2]};
                tracker.check_result(got);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!hold_done && beats_counted >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog: end the run when no channel moves a beat for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_sliding_window_slope_convergence_unit: FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        int i;
        int p;
        tracker = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Clear with every other field set, then offers that must be ignored
        send_item(make_beat(1'b1, 24'hFFFFFF, 48'hFFFF_FFFF_FFFF, 1'b1));
        send_item(make_beat(1'b0, 24'd5, Q_MAX, 1'b0));
        send_item(make_beat(1'b0, 24'd0, Q_MIN, 1'b1));
        // Steep rise between the value extremes gives a large positive slope
        send_item(make_beat(1'b0, 24'd1, Q_MIN, 1'b1));
        send_item(make_beat(1'b0, 24'd2, 48'd0, 1'b1));
        send_item(make_beat(1'b0, 24'd3, 48'd0, 1'b1));
        send_item(make_beat(1'b0, 24'd4, Q_MAX, 1'b1));
        // Steep fall gives a large negative slope; a step going back is ignored
        send_item(make_beat(1'b1, 24'd0, 48'd0, 1'b0));
        send_item(make_beat(1'b0, 24'd1, Q_MAX, 1'b1));
        send_item(make_beat(1'b0, 24'd2, 48'd0, 1'b1));
        send_item(make_beat(1'b0, 24'd3, 48'd0, 1'b1));
        send_item(make_beat(1'b0, 24'd4, Q_MIN, 1'b1));
        send_item(make_beat(1'b0, 24'd2, Q_MAX, 1'b1));
        // Flat run ending at the top step converges
        send_item(make_beat(1'b1, 24'd0, 48'd0, 1'b0));
        for (i = 0; i < 6; i++)
            send_item(make_beat(1'b0, 24'(24'hFFFFFA + i), 48'h2A00_0000_0000, 1'b1));

        // Zero interval: equal steps are taken but the fit is degenerate
        settle();
        program_regs(16'd0, TOL_MAX);
        send_item(make_beat(1'b1, 24'd0, 48'd0, 1'b0));
        for (i = 0; i < 4; i++)
            send_item(make_beat(1'b0, 24'd100, random_q740(), 1'b1));
        send_item(make_beat(1'b0, 24'd101, random_q740(), 1'b1));

        // Random phases over several register settings and idle patterns
        for (p = 0; p < 6; p++)
        begin
            settle();
            case (p)
                0: program_regs(INTERVAL_RST, TOLERANCE_RST);
                1: program_regs(16'hFFFF, '0);
                2: program_regs(16'd0, TOL_MAX);
                3: program_regs(16'($urandom_range(2, 50)), 47'({$urandom, $urandom}));
                4: program_regs(16'($urandom_range(1, 4)), 47'd1 << $urandom_range(0, 46));
                default: program_regs(16'($urandom_range(1, 65535)),
                                      47'($urandom_range(0, 1 << 20)));
            endcase
            send_idle_pct = (p < 2) ? 33 : (p < 4) ? 62 : 0;
            recv_idle_pct = (p < 2) ? 62 : (p < 4) ? 33 : 0;
            run_random(PHASE_BEATS);
        end

        settle();
        tracker.close_out();
        if (tracker.faults == 0)
            $display("tb_sliding_window_slope_convergence_unit: PASS");
        else
            $display("tb_sliding_window_slope_convergence_unit: FAIL");
        $finish;
    end
endmodule

>>> sim.f
rtl/swsc_pkg.sv
rtl/swsc_datapath.sv
rtl/swsc_ctrl.sv
rtl/sliding_window_slope_convergence_unit.sv
rtl/swsc_checker.sv
verif/tb_sliding_window_slope_convergence_unit.sv
